// ===== sv/scan_code_to_ascii_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Scan code decoder assertion macros
// Shared assertion forms used by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_ASCII_DECODER_CORE_DEFINES_SVH
`define SCAN_CODE_TO_ASCII_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define SC2A_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sc2a: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define SC2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sc2a: next-cycle check failed");

`endif

// ===== sv/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, key codes and the key table of the scan code set 1 decoder.
// ----------------------------------------------------------------------------
package sc2a_pkg;

	// prefix tracking; code 3 is unused and handled like E1
	typedef enum logic [1:0] {
		PFX_NORMAL = 2'd0,
		PFX_E0     = 2'd1,
		PFX_E1     = 2'd2
	} prefix_t;

	typedef struct packed {
		prefix_t prefix;
		logic    lshift;
		logic    rshift;
		logic    caps;
		logic    lctrl;
		logic    rctrl;
		logic    lalt;
		logic    ralt;
	} key_state_t;

	typedef struct packed {
		logic [6:0] plain;
		logic [6:0] shifted;
	} key_pair_t;

	localparam logic [7:0] SC_PRE_E0 = 8'hE0;
	localparam logic [7:0] SC_PRE_E1 = 8'hE1;
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CTRL   = 7'h1D;
	localparam logic [6:0] SC_ALT    = 7'h38;
	localparam logic [6:0] SC_CAPS   = 7'h3A;
	localparam logic [6:0] SC_F1     = 7'h3B;
	localparam logic [6:0] SC_F10    = 7'h44;
	localparam logic [6:0] SC_F11    = 7'h57;
	localparam logic [6:0] SC_F12    = 7'h58;

	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_UPPER_Z = 7'h5A;
	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_LOWER_Z = 7'h7A;
	localparam int         CASE_BIT   = 5;

	// normal and shifted character per key number; unmapped keys give 0
	function automatic key_pair_t key_rom(input logic [6:0] k);
		key_pair_t p;
		p = '{plain: 7'h00, shifted: 7'h00};
		case (k)
			7'h02: p = '{7'h31, 7'h21};
			7'h03: p = '{7'h32, 7'h40};
			7'h04: p = '{7'h33, 7'h23};
			7'h05: p = '{7'h34, 7'h24};
			7'h06: p = '{7'h35, 7'h25};
			7'h07: p = '{7'h36, 7'h5E};
			7'h08: p = '{7'h37, 7'h26};
			7'h09: p = '{7'h38, 7'h2A};
			7'h0A: p = '{7'h39, 7'h28};
			7'h0B: p = '{7'h30, 7'h29};
			7'h0C: p = '{7'h2D, 7'h5F};
			7'h0D: p = '{7'h3D, 7'h2B};
			7'h0E: p = '{7'h08, 7'h08};
			7'h0F: p = '{7'h09, 7'h09};
			7'h10: p = '{7'h71, 7'h51};
			7'h11: p = '{7'h77, 7'h57};
			7'h12: p = '{7'h65, 7'h45};
			7'h13: p = '{7'h72, 7'h52};
			7'h14: p = '{7'h74, 7'h54};
			7'h15: p = '{7'h79, 7'h59};
			7'h16: p = '{7'h75, 7'h55};
			7'h17: p = '{7'h69, 7'h49};
			7'h18: p = '{7'h6F, 7'h4F};
			7'h19: p = '{7'h70, 7'h50};
			7'h1A: p = '{7'h5B, 7'h7B};
			7'h1B: p = '{7'h5D, 7'h7D};
			7'h1C: p = '{7'h0A, 7'h0A};
			7'h1E: p = '{7'h61, 7'h41};
			7'h1F: p = '{7'h73, 7'h53};
			7'h20: p = '{7'h64, 7'h44};
			7'h21: p = '{7'h66, 7'h46};
			7'h22: p = '{7'h67, 7'h47};
			7'h23: p = '{7'h68, 7'h48};
			7'h24: p = '{7'h6A, 7'h4A};
			7'h25: p = '{7'h6B, 7'h4B};
			7'h26: p = '{7'h6C, 7'h4C};
			7'h27: p = '{7'h3B, 7'h3A};
			7'h28: p = '{7'h27, 7'h22};
			7'h29: p = '{7'h60, 7'h7E};
			7'h2B: p = '{7'h5C, 7'h7C};
			7'h2C: p = '{7'h7A, 7'h5A};
			7'h2D: p = '{7'h78, 7'h58};
			7'h2E: p = '{7'h63, 7'h43};
			7'h2F: p = '{7'h76, 7'h56};
			7'h30: p = '{7'h62, 7'h42};
			7'h31: p = '{7'h6E, 7'h4E};
			7'h32: p = '{7'h6D, 7'h4D};
			7'h33: p = '{7'h2C, 7'h3C};
			7'h34: p = '{7'h2E, 7'h3E};
			7'h35: p = '{7'h2F, 7'h3F};
			7'h39: p = '{7'h20, 7'h20};
			default: p = '{plain: 7'h00, shifted: 7'h00};
		endcase
		return p;
	endfunction

endpackage

// ===== sv/sc2a_decode.sv =====
// ----------------------------------------------------------------------------
// sc2a_decode
// One-byte decode step: next key state, result strobe and character.
// ----------------------------------------------------------------------------
module sc2a_decode (
	input  logic [7:0]             scan_byte,
	input  sc2a_pkg::key_state_t   state,
	output sc2a_pkg::key_state_t   state_nxt,
	output logic                   emit,
	output logic [6:0]             ascii_char
);

	logic [6:0]          k;
	logic                make;
	logic                shift_on;
	sc2a_pkg::key_pair_t pair;
	logic [6:0]          ch_raw;
	logic                is_letter;

	assign k        = scan_byte[6:0];
	assign make     = ~scan_byte[7];
	assign shift_on = state.lshift | state.rshift;

	always_comb begin
		state_nxt = state;
		emit      = 1'b0;
		if (scan_byte == sc2a_pkg::SC_PRE_E0) begin
			state_nxt.prefix = sc2a_pkg::PFX_E0;
		end else if (scan_byte == sc2a_pkg::SC_PRE_E1) begin
			state_nxt.prefix = sc2a_pkg::PFX_E1;
		end else begin
			case (state.prefix)
				sc2a_pkg::PFX_NORMAL: begin
					case (k)
						sc2a_pkg::SC_LSHIFT: state_nxt.lshift = make;
						sc2a_pkg::SC_RSHIFT: state_nxt.rshift = make;
						sc2a_pkg::SC_CTRL:   state_nxt.lctrl  = make;
						sc2a_pkg::SC_ALT:    state_nxt.lalt   = make;
						sc2a_pkg::SC_CAPS:   state_nxt.caps   = state.caps ^ make;
						default: begin
							// drop function keys and all breaks
							emit = make && !(k inside {[sc2a_pkg::SC_F1:sc2a_pkg::SC_F10],
								sc2a_pkg::SC_F11, sc2a_pkg::SC_F12});
						end
					endcase
				end
				sc2a_pkg::PFX_E0: begin
					if (k == sc2a_pkg::SC_CTRL) begin
						state_nxt.rctrl = make;
					end else if (k == sc2a_pkg::SC_ALT) begin
						state_nxt.ralt = make;
					end
					state_nxt.prefix = sc2a_pkg::PFX_NORMAL;
				end
				default: begin
					// swallow the byte after E1
					state_nxt.prefix = sc2a_pkg::PFX_NORMAL;
				end
			endcase
		end
	end

	assign pair      = sc2a_pkg::key_rom(k);
	assign ch_raw    = shift_on ? pair.shifted : pair.plain;
	assign is_letter = (ch_raw inside {[sc2a_pkg::CH_UPPER_A:sc2a_pkg::CH_UPPER_Z],
		[sc2a_pkg::CH_LOWER_A:sc2a_pkg::CH_LOWER_Z]});

	always_comb begin
		ascii_char = ch_raw;
		if (state.caps && is_letter) begin
			ascii_char[sc2a_pkg::CASE_BIT] = ~ch_raw[sc2a_pkg::CASE_BIT];
		end
	end

endmodule

// ===== sv/scan_code_to_ascii_decoder_core.sv =====
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder_core
// Scan code set 1 byte stream to character stream with modifier flags.
// ----------------------------------------------------------------------------
// Takes one keyboard byte per request and accepts a new byte every cycle
// while the input is not stalled. A byte lands in an input register, is
// decoded by a single table lookup and flag update, and its character (if
// any) lands in a result register, which drives the output request.
// Prefix bytes (E0, E1), modifier and caps lock keys, function keys,
// breaks and the bytes after E0 and E1 update state only and produce no
// request on the output. Every other make code produces exactly one
// request carrying the character (0 for an unmapped key, case swapped for
// letters while caps lock is on) and the shift, ctrl and alt flags as they
// stood before that byte. The result register frees the input side: a
// waiting character stalls the input only when the next byte also
// produces a character.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_ready,
	input  logic [7:0] scan_byte,
	output logic       char_valid,
	input  logic       char_ready,
	output logic [6:0] ascii_char,
	output logic       shift_held,
	output logic       ctrl_held,
	output logic       alt_held
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// key state
	sc2a_pkg::key_state_t state_q;
	sc2a_pkg::key_state_t state_nxt;

	// result register
	logic       char_valid_q;
	logic [6:0] ascii_q;
	logic       shift_q;
	logic       ctrl_q;
	logic       alt_q;

	logic       emit;
	logic [6:0] char_w;
	logic       advance;
	logic       fire_s1;

	sc2a_decode u_decode (
		.scan_byte  (byte_s1),
		.state      (state_q),
		.state_nxt  (state_nxt),
		.emit       (emit),
		.ascii_char (char_w)
	);

	// advance the input stage unless its character has nowhere to go
	assign advance    = !emit || !char_valid_q || char_ready;
	assign fire_s1    = valid_s1 && advance;
	assign scan_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_ready) begin
			valid_s1 <= scan_valid;
		end
	end

	// hold the byte while stalled
	always_ff @(posedge clk) begin
		if (scan_valid && scan_ready) begin
			byte_s1 <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{prefix: sc2a_pkg::PFX_NORMAL, default: 1'b0};
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			char_valid_q <= 1'b1;
		end else if (char_ready) begin
			char_valid_q <= 1'b0;
		end
	end

	// modifiers are reported as held before this byte
	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			ascii_q <= char_w;
			shift_q <= state_q.lshift | state_q.rshift;
			ctrl_q  <= state_q.lctrl | state_q.rctrl;
			alt_q   <= state_q.lalt | state_q.ralt;
		end
	end

	assign char_valid = char_valid_q;
	assign ascii_char = ascii_q;
	assign shift_held = shift_q;
	assign ctrl_held  = ctrl_q;
	assign alt_held   = alt_q;

endmodule

// ===== sv/sc2a_checker.sv =====
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks of the scan code decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_code_to_ascii_decoder_core_defines.svh"

module sc2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       scan_valid,
	input logic       scan_ready,
	input logic [7:0] scan_byte,
	input logic       char_valid,
	input logic       char_ready,
	input logic [6:0] ascii_char,
	input logic       shift_held,
	input logic       ctrl_held,
	input logic       alt_held
);

	logic scan_fire;

	assign scan_fire = scan_valid && scan_ready;

	// a stalled byte request holds its payload
	`SC2A_ASSERT_NEXT(a_in_hold, clk, arst_n, scan_valid && !scan_ready, scan_valid && $stable(scan_byte))

	// a stalled character request holds its payload
	`SC2A_ASSERT_NEXT(a_out_hold, clk, arst_n, char_valid && !char_ready, char_valid && $stable(ascii_char) && $stable(shift_held) && $stable(ctrl_held) && $stable(alt_held))

	// an empty result register never blocks input
	`SC2A_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !char_valid, scan_ready)

	// a new character follows a byte taken through the input register
	`SC2A_ASSERT_SAME(a_char_has_byte, clk, arst_n, $rose(char_valid), $past(scan_fire, 2))

endmodule

bind scan_code_to_ascii_decoder_core sc2a_checker u_sc2a_checker (.*);
